// File: hdl/zero_crossing_frequency_estimator_assert.svh
// Assertion macros for the zero crossing frequency estimator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ZERO_CROSSING_FREQUENCY_ESTIMATOR_ASSERT_SVH
`define ZERO_CROSSING_FREQUENCY_ESTIMATOR_ASSERT_SVH

// Same-cycle implication.
`define ZCFE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zcfe assertion failed");

// Next-cycle implication.
`define ZCFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zcfe assertion failed");

`endif

// File: hdl/zcfe_pkg.sv
// Package for the zero crossing frequency estimator: payload types,
// register indexes, sequencer states and fixed-point constants. No dependencies.
package zcfe_pkg;

   localparam int SampleBits = 16;
   localparam int TimeBits   = 32;
   localparam int IndexBits  = 16;
   localparam int FracBits   = 60 - TimeBits;           // interpolation fraction bits
   localparam int DivSteps   = 16 + 31 + FracBits;      // final quotient steps
   localparam int CountBits  = 16;
   localparam int StepBits   = 7;

   localparam logic [IndexBits-1:0] WindowStartReset = '0;
   localparam logic [IndexBits-1:0] WindowEndReset   = IndexBits'(65535);
   localparam logic [15:0]          HystReset        = 16'd4096;

   typedef enum logic [1:0] {
      CSR_WINDOW_START = 2'd0,
      CSR_WINDOW_END   = 2'd1,
      CSR_HYST         = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] sample;
      logic [SampleBits-1:0]        envelope;
      logic [TimeBits-1:0]          sample_time;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic [31:0]          frequency;
      logic [CountBits-1:0] crossings;
      logic                 valid_res;
   } rsp_type;

   // Sample/time pairs around the first and the last crossing.
   typedef struct packed {
      logic signed [SampleBits-1:0] first_s0;
      logic signed [SampleBits-1:0] first_s1;
      logic [TimeBits-1:0]          first_t0;
      logic [TimeBits-1:0]          first_t1;
      logic signed [SampleBits-1:0] last_s0;
      logic signed [SampleBits-1:0] last_s1;
      logic [TimeBits-1:0]          last_t0;
      logic [TimeBits-1:0]          last_t1;
   } cross_store_type;

   typedef enum logic [2:0] {
      FIN_IDLE,
      FIN_FRAC_I,
      FIN_FRAC_F,
      FIN_MUL_F,
      FIN_MUL_I,
      FIN_DIV,
      FIN_DONE
   } fin_state_type;

endpackage

// File: hdl/zcfe_alu.sv
// Shared 64-bit add/subtract unit with carry out, used for every
// divide and multiply step. Depends on nothing.
module zcfe_alu (
   input  logic [63:0] a,
   input  logic [63:0] b,
   input  logic        sub,
   output logic [63:0] sum,
   output logic        carry
);

   logic [64:0] total;

   // carry = 1 on subtract means a >= b (unsigned)
   assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {64'd0, sub};
   assign sum   = total[63:0];
   assign carry = total[64];

endmodule

// File: hdl/zcfe_track.sv
// Per-sample window, sign and hysteresis tracking plus crossing stores.
// Depends on zcfe_pkg.
module zcfe_track
   import zcfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  req_type               req,
   input  logic [IndexBits-1:0]  window_start,
   input  logic [IndexBits-1:0]  window_end,
   input  logic [15:0]           hyst_fraction,
   output logic [CountBits-1:0]  count_next,
   output cross_store_type       store,
   output cross_store_type       store_next
);

   logic [IndexBits:0]   idx_ff, idx_in;
   logic                 sign_ff, sign_in;
   logic                 hyst_ff, hyst_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [SampleBits-1:0] prev_s_ff, prev_s_in;
   logic [TimeBits-1:0]  prev_t_ff, prev_t_in;
   cross_store_type      store_ff, store_in;

   logic                 in_win, at_start, pos_now, hyst_hold, cross_hit;
   logic [SampleBits:0]  s_ext, mag;
   logic [SampleBits+12:0] lhs;
   logic [2*SampleBits-1:0] rhs;

   always_comb begin
      s_ext     = {req.sample[SampleBits-1], req.sample};
      mag       = req.sample[SampleBits-1] ? (~s_ext + (SampleBits+1)'(1)) : s_ext;
      lhs       = {mag, 12'd0};
      rhs       = (2*SampleBits)'(hyst_fraction) * (2*SampleBits)'(req.envelope);
      hyst_hold = (2*SampleBits+13)'(lhs) > (2*SampleBits+13)'(rhs);
      pos_now   = ~req.sample[SampleBits-1];
      in_win    = (idx_ff >= {1'b0, window_start}) && (idx_ff < {1'b0, window_end});
      at_start  = idx_ff == {1'b0, window_start};
      cross_hit = in_win && !at_start && !hyst_ff && (pos_now != sign_ff);
   end

   always_comb begin
      idx_in     = idx_ff;
      sign_in    = sign_ff;
      hyst_in    = hyst_ff;
      count_in   = count_ff;
      prev_s_in  = prev_s_ff;
      prev_t_in  = prev_t_ff;
      store_in   = store_ff;
      count_next = count_ff;
      if (in_win) begin
         if (at_start) begin
            sign_in = pos_now;
            hyst_in = 1'b0;
         end else if (hyst_ff) begin
            hyst_in = hyst_hold;
         end else if (cross_hit) begin
            if (count_ff == '0) begin
               store_in.first_s0 = prev_s_ff;
               store_in.first_s1 = req.sample;
               store_in.first_t0 = prev_t_ff;
               store_in.first_t1 = req.sample_time;
            end
            store_in.last_s0 = prev_s_ff;
            store_in.last_s1 = req.sample;
            store_in.last_t0 = prev_t_ff;
            store_in.last_t1 = req.sample_time;
            if (count_ff != '1) begin
               count_in = count_ff + CountBits'(1);
            end
            sign_in = pos_now;
            hyst_in = 1'b1;
         end
      end
      count_next = count_in;
      prev_s_in  = req.sample;
      prev_t_in  = req.sample_time;
      if (idx_ff != '1) begin
         idx_in = idx_ff + (IndexBits+1)'(1);
      end
      if (req.last) begin
         idx_in    = '0;
         sign_in   = 1'b0;
         hyst_in   = 1'b0;
         count_in  = '0;
         prev_s_in = '0;
         prev_t_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         sign_ff   <= 1'b0;
         hyst_ff   <= 1'b0;
         count_ff  <= '0;
         prev_s_ff <= '0;
         prev_t_ff <= '0;
      end else if (accept) begin
         idx_ff    <= idx_in;
         sign_ff   <= sign_in;
         hyst_ff   <= hyst_in;
         count_ff  <= count_in;
         prev_s_ff <= prev_s_in;
         prev_t_ff <= prev_t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
   end

   assign store      = store_ff;
   // includes a crossing on the sample being transferred
   assign store_next = store_in;

endmodule

// File: hdl/zcfe_finish.sv
// End-of-record sequencer: fractions, interpolated span and frequency
// quotient, all stepped through the shared zcfe_alu. Depends on zcfe_pkg.
module zcfe_finish
   import zcfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CountBits-1:0] count_next,
   input  cross_store_type      store,
   input  cross_store_type      store_next,
   input  logic                 rsp_stall,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_type              rsp_payload
);

   localparam logic [FracBits:0] FracOne = (FracBits+1)'(1) << FracBits;

   fin_state_type state_ff, state_in;

   logic [63:0]          r_ff, r_in, d_ff, d_in, mc_ff, mc_in, acc_ff, acc_in;
   logic [31:0]          q_ff, q_in;
   logic [FracBits:0]    fi_ff, fi_in, mp_ff, mp_in;
   logic [SampleBits:0]  af_ff, af_in, df_ff, df_in;
   logic                 clamp_i_ff, clamp_i_in, clamp_f_ff, clamp_f_in;
   logic                 sat_ff, sat_in;
   logic [CountBits-1:0] num_ff, num_in, cross_ff, cross_in;
   logic [StepBits-1:0]  cnt_ff, cnt_in;
   logic [31:0]          freq_ff, freq_in;
   logic                 ok_ff, ok_in;

   logic [63:0] alu_a, alu_b, alu_sum, r_shift;
   logic        alu_sub, alu_carry;
   logic [SampleBits:0] di, ai, df, af;
   logic [FracBits:0]   frac_done;
   logic [TimeBits:0]   dt_span, dt_last, dt_first;
   logic signed [63:0]  acc_last;
   logic [31:0]         q_step;
   logic                sat_step;

   zcfe_alu u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   function automatic logic [SampleBits:0] abs_diff(logic signed [SampleBits-1:0] x,
                                                   logic signed [SampleBits-1:0] y);
      logic signed [SampleBits:0] v;
      v = {x[SampleBits-1], x} - {y[SampleBits-1], y};
      return v[SampleBits] ? (~v + (SampleBits+1)'(1)) : v;
   endfunction

   // Sample magnitudes are taken at the start, before the last sample lands
   // in the stores; time differences are read later from the stores.
   always_comb begin
      di = abs_diff(store_next.first_s0, store_next.first_s1);
      ai = abs_diff(store_next.first_s1, '0);
      df = abs_diff(store_next.last_s0, store_next.last_s1);
      af = abs_diff(store_next.last_s1, '0);
      dt_span  = {1'b0, store.last_t1} - {1'b0, store.first_t1};
      dt_last  = {1'b0, store.last_t0} - {1'b0, store.last_t1};
      dt_first = {1'b0, store.first_t0} - {1'b0, store.first_t1};
   end

   // Shared unit operand selection.
   always_comb begin
      r_shift = {r_ff[62:0], 1'b0};
      alu_a   = r_shift;
      alu_b   = d_ff;
      alu_sub = 1'b1;
      unique case (state_ff)
         FIN_MUL_F: begin
            alu_a   = acc_ff;
            alu_b   = mc_ff;
            alu_sub = 1'b0;
         end
         FIN_MUL_I: begin
            alu_a   = acc_ff;
            alu_b   = mc_ff;
            alu_sub = 1'b1;
         end
         FIN_DIV: begin
            r_shift = {r_ff[62:0], num_ff[CountBits-1]};
            alu_a   = r_shift;
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FIN_IDLE: begin
            if (start) begin
               if (count_next < CountBits'(2) || di == '0 || df == '0) begin
                  state_in = FIN_DONE;
               end else begin
                  state_in = FIN_FRAC_I;
               end
            end
         end
         FIN_FRAC_I: if (cnt_ff == StepBits'(FracBits-1)) state_in = FIN_FRAC_F;
         FIN_FRAC_F: if (cnt_ff == StepBits'(FracBits-1)) state_in = FIN_MUL_F;
         FIN_MUL_F:  if (cnt_ff == StepBits'(FracBits)) state_in = FIN_MUL_I;
         FIN_MUL_I: begin
            if (cnt_ff == StepBits'(FracBits)) begin
               state_in = (acc_last > 64'sd0) ? FIN_DIV : FIN_DONE;
            end
         end
         FIN_DIV:    if (cnt_ff == StepBits'(DivSteps-1)) state_in = FIN_DONE;
         FIN_DONE:   if (!rsp_stall) state_in = FIN_IDLE;
         default:    state_in = FIN_IDLE;
      endcase
   end

   // Datapath.
   always_comb begin
      r_in       = r_ff;
      d_in       = d_ff;
      mc_in      = mc_ff;
      acc_in     = acc_ff;
      q_in       = q_ff;
      fi_in      = fi_ff;
      mp_in      = mp_ff;
      af_in      = af_ff;
      df_in      = df_ff;
      clamp_i_in = clamp_i_ff;
      clamp_f_in = clamp_f_ff;
      sat_in     = sat_ff;
      num_in     = num_ff;
      cross_in   = cross_ff;
      cnt_in     = cnt_ff + StepBits'(1);
      freq_in    = freq_ff;
      ok_in      = ok_ff;
      frac_done  = '0;
      acc_last   = acc_ff;
      q_step     = q_ff;
      sat_step   = sat_ff;

      unique case (state_ff)
         FIN_IDLE: begin
            cnt_in     = '0;
            cross_in   = count_next;
            num_in     = count_next - CountBits'(1);
            r_in       = 64'(ai);
            d_in       = 64'(di);
            q_in       = '0;
            af_in      = af;
            df_in      = df;
            clamp_i_in = ai >= di;
            clamp_f_in = af >= df;
            freq_in    = '0;
            ok_in      = 1'b0;
         end
         FIN_FRAC_I, FIN_FRAC_F: begin
            r_in = alu_carry ? alu_sum : r_shift;
            q_in = {q_ff[30:0], alu_carry};
            frac_done = (FracBits+1)'({q_ff[30:0], alu_carry});
            if (cnt_ff == StepBits'(FracBits-1)) begin
               cnt_in = '0;
               if (state_ff == FIN_FRAC_I) begin
                  fi_in = clamp_i_ff ? FracOne : frac_done;
                  r_in  = 64'(af_ff);
                  d_in  = 64'(df_ff);
                  q_in  = '0;
               end else begin
                  mp_in  = clamp_f_ff ? FracOne : frac_done;
                  acc_in = {{(64-TimeBits-1-FracBits){dt_span[TimeBits]}}, dt_span,
                            {FracBits{1'b0}}};
                  mc_in  = {{(64-TimeBits-1){dt_last[TimeBits]}}, dt_last};
               end
            end
         end
         FIN_MUL_F, FIN_MUL_I: begin
            if (mp_ff[0]) begin
               acc_in = alu_sum;
            end
            acc_last = mp_ff[0] ? alu_sum : acc_ff;
            mc_in    = {mc_ff[62:0], 1'b0};
            mp_in    = mp_ff >> 1;
            if (cnt_ff == StepBits'(FracBits)) begin
               cnt_in = '0;
               if (state_ff == FIN_MUL_F) begin
                  mc_in = {{(64-TimeBits-1){dt_first[TimeBits]}}, dt_first};
                  mp_in = fi_ff;
               end else begin
                  d_in   = acc_last;
                  r_in   = '0;
                  q_in   = '0;
                  sat_in = 1'b0;
               end
            end
         end
         FIN_DIV: begin
            r_in   = alu_carry ? alu_sum : r_shift;
            num_in = {num_ff[CountBits-2:0], 1'b0};
            if (!sat_ff) begin
               if (q_ff[31]) begin
                  sat_step = 1'b1;
               end else begin
                  q_step = {q_ff[30:0], alu_carry};
               end
            end
            q_in   = q_step;
            sat_in = sat_step;
            if (cnt_ff == StepBits'(DivSteps-1)) begin
               freq_in = sat_step ? '1 : q_step;
               ok_in   = 1'b1;
            end
         end
         FIN_DONE: begin
            cnt_in = cnt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff       <= r_in;
      d_ff       <= d_in;
      mc_ff      <= mc_in;
      acc_ff     <= acc_in;
      q_ff       <= q_in;
      fi_ff      <= fi_in;
      mp_ff      <= mp_in;
      af_ff      <= af_in;
      df_ff      <= df_in;
      clamp_i_ff <= clamp_i_in;
      clamp_f_ff <= clamp_f_in;
      sat_ff     <= sat_in;
      num_ff     <= num_in;
      cross_ff   <= cross_in;
      cnt_ff     <= cnt_in;
      freq_ff    <= freq_in;
      ok_ff      <= ok_in;
   end

   // Outputs.
   always_comb begin
      busy                  = state_ff != FIN_IDLE;
      rsp_valid             = state_ff == FIN_DONE;
      rsp_payload.frequency = freq_ff;
      rsp_payload.crossings = cross_ff;
      rsp_payload.valid_res = ok_ff;
   end

endmodule

// File: hdl/zero_crossing_frequency_estimator.sv
// Top level of the zero crossing frequency estimator: control registers,
// sample tracker and end-of-record sequencer. Depends on zcfe_pkg,
// zcfe_track, zcfe_finish (and zcfe_alu below it).
//
//   channel | direction | handshake        | payload
//   req_    | in        | req_valid/stall  | req_type: sample, envelope, sample_time, last
//   rsp_    | out       | rsp_valid/stall  | rsp_type: frequency, crossings, valid_res
//   csr_    | in        | csr_valid/ready  | csr_index, csr_data
//
// Ordinary samples stream back to back while the sequencer is not busy.
// The sample marked last starts the finish sequencer: 2*28 fraction steps,
// 2*29 multiply steps and 75 quotient steps on the shared adder; records
// that cannot be valid go to the result from idle or after the multiply steps.
// req_stall stays high until the result transfers.
// Synchronous reset clears the record state and restores register defaults.
// rsp_stall only holds the result; nothing is lost or repeated.
module zero_crossing_frequency_estimator
   import zcfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   // control register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [IndexBits-1:0] win_start_ff, win_start_in;
   logic [IndexBits-1:0] win_end_ff, win_end_in;
   logic [15:0]          hyst_ff, hyst_in;

   logic                 req_accept, busy;
   logic [CountBits-1:0] count_next;
   cross_store_type      store, store_next;

   assign csr_ready  = 1'b1;
   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;

   // Register file; writes to the unused index are dropped.
   always_comb begin
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      hyst_in      = hyst_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_START: win_start_in = IndexBits'(csr_data);
            CSR_WINDOW_END:   win_end_in   = IndexBits'(csr_data);
            CSR_HYST:         hyst_in      = csr_data;
            CSR_UNUSED:       begin end
            default:          begin end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= WindowStartReset;
         win_end_ff   <= WindowEndReset;
         hyst_ff      <= HystReset;
      end else begin
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         hyst_ff      <= hyst_in;
      end
   end

   // Per-sample tracking: one transfer per cycle while not busy.
   zcfe_track u_track (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .req           (req_payload),
      .window_start  (win_start_ff),
      .window_end    (win_end_ff),
      .hyst_fraction (hyst_ff),
      .count_next    (count_next),
      .store         (store),
      .store_next    (store_next)
   );

   // Record finish: starts on the transfer of the last sample.
   zcfe_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept && req_payload.last),
      .count_next  (count_next),
      .store       (store),
      .store_next  (store_next),
      .rsp_stall   (rsp_stall),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/zcfe_checker.sv
// Port-level checker for the zero crossing frequency estimator, bound to
// the top level. Depends on zcfe_pkg and the assertion macro header.
`include "zero_crossing_frequency_estimator_assert.svh"

module zcfe_checker
   import zcfe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input req_type     req_payload,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_payload,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);

   `ZCFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `ZCFE_ASSERT_IMPLY(a_busy_on_rsp, clock, reset, rsp_valid, req_stall)
   `ZCFE_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && !rsp_payload.valid_res, rsp_payload.frequency == 32'd0)
   `ZCFE_ASSERT_IMPLY(a_few_crossings, clock, reset, rsp_valid && rsp_payload.crossings < 16'd2, !rsp_payload.valid_res)

endmodule

bind zero_crossing_frequency_estimator zcfe_checker u_zcfe_checker (.*);

// File: tb/zcfe_checker.sv
`timescale 1ns / 1ps
// Checker for the zero crossing frequency estimator: watches sample, result and
// register transfers, predicts each record's frequency result and compares it.
// Depends on zcfe_pkg.
module zcfe_tb_checker
   import zcfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   logic [15:0] win_lo, win_hi, hyst;
   logic [16:0] idx;
   logic        pos_ref, armed;
   logic [15:0] n_cross;
   logic signed [15:0] prev_s;
   logic [31:0] prev_t;
   logic signed [15:0] fs0, fs1, ls0, ls1;
   logic [31:0] ft0, ft1, lt0, lt1;
   rsp_type     freq_results[$];

   assign pending_count = freq_results.size();

   // |wc/(wp-wc)| in Q1.FracBits, clamped to one; ok=0 on a zero divisor
   function automatic logic signed [63:0] cross_frac(input logic signed [15:0] wp,
         input logic signed [15:0] wc, output bit ok);
      longint d, a, r, q;
      d = longint'(wp) - longint'(wc);
      if (d < 0) d = -d;
      a = longint'(wc);
      if (a < 0) a = -a;
      ok = (d != 0);
      if (d == 0) return 0;
      if (a >= d) return 64'sd1 <<< FracBits;
      r = a;
      q = 0;
      for (int k = 0; k < FracBits; k++) begin
         r = r <<< 1;
         q = q <<< 1;
         if (r >= d) begin
            r -= d;
            q |= 1;
         end
      end
      return q;
   endfunction

   function automatic rsp_type record_result();
      rsp_type res;
      longint fi, ff, span;
      logic [127:0] quo;
      bit ok_i, ok_f;
      res = '0;
      res.crossings = n_cross;
      if (n_cross < 2) return res;
      fi = cross_frac(fs0, fs1, ok_i);
      ff = cross_frac(ls0, ls1, ok_f);
      if (!ok_i || !ok_f) return res;
      span = (longint'(lt1) - longint'(ft1)) * (64'sd1 <<< FracBits)
           + ff * (longint'(lt0) - longint'(lt1))
           - fi * (longint'(ft0) - longint'(ft1));
      if (span <= 0) return res;
      quo = ({112'd0, n_cross - 16'd1} << (31 + FracBits)) / 128'(span);
      res.frequency = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
      res.valid_res = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      logic [15:0] mag;
      int errs;
      if (reset) begin
         win_lo <= WindowStartReset;
         win_hi <= WindowEndReset;
         hyst <= HystReset;
         idx = 0; pos_ref = 0; armed = 0; n_cross = 0; prev_s = 0; prev_t = 0;
         fail_count <= 0;
      end else begin
         errs = 0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_START: win_lo <= csr_data;
               CSR_WINDOW_END:   win_hi <= csr_data;
               CSR_HYST:         hyst <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (idx >= {1'b0, win_lo} && idx < {1'b0, win_hi}) begin
               mag = req_payload.sample[15] ? -req_payload.sample : req_payload.sample;
               if (idx == {1'b0, win_lo}) begin
                  pos_ref = !req_payload.sample[15];
                  armed = 0;
               end else if (armed) begin
                  armed = ({4'd0, mag, 12'd0} > 32'(hyst) * 32'(req_payload.envelope));
               end else if (!req_payload.sample[15] != pos_ref) begin
                  if (n_cross == 0) begin
                     fs0 = prev_s; fs1 = req_payload.sample;
                     ft0 = prev_t; ft1 = req_payload.sample_time;
                  end
                  ls0 = prev_s; ls1 = req_payload.sample;
                  lt0 = prev_t; lt1 = req_payload.sample_time;
                  if (n_cross != 16'hFFFF) n_cross++;
                  pos_ref = !req_payload.sample[15];
                  armed = 1;
               end
            end
            prev_s = req_payload.sample;
            prev_t = req_payload.sample_time;
            if (idx != 17'h1FFFF) idx++;
            if (req_payload.last) begin
               freq_results = {freq_results, record_result()};
               idx = 0; pos_ref = 0; armed = 0; n_cross = 0; prev_s = 0; prev_t = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (freq_results.size() == 0) begin
               $error("unexpected result transfer");
               errs++;
            end else begin
               want = freq_results.pop_front();
               if (want.frequency !== rsp_payload.frequency) begin
                  $error("frequency: expected %h, got %h", want.frequency,
                     rsp_payload.frequency);
                  errs++;
               end
               if (want.crossings !== rsp_payload.crossings) begin
                  $error("crossings: expected %0d, got %0d", want.crossings,
                     rsp_payload.crossings);
                  errs++;
               end
               if (want.valid_res !== rsp_payload.valid_res) begin
                  $error("valid_res: expected %b, got %b", want.valid_res,
                     rsp_payload.valid_res);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the zero crossing frequency estimator testbench: clock, reset, sample
// and register stimulus, stall pressure and verdict. Depends on zcfe_pkg,
// zcfe_tb_checker and the estimator RTL.
module tb;
   import zcfe_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid, rsp_stall = 0;
   rsp_type     rsp_payload;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_index = CSR_WINDOW_START;
   logic [15:0] csr_data = 0;
   int          fail_count, pending_count;
   int          send_idle = 0, recv_stall = 0;   // percent of cycles
   int          cycle = 0;
   logic [31:0] now_time = 0;                     // running time stamp

   localparam int CycleLimit = 1000000;
   localparam int FinishLatency = 250;           // sequencer run plus margin

   always #5 clock = ~clock;

   zero_crossing_frequency_estimator dut (.*);

   zcfe_tb_checker chk (.*);

   // receiver pressure: random stall at the current rate
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall);

   // run watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // register write, only while the block is idle; valid stays up for the
   // next write and is dropped by csr_idle
   task automatic write_reg(input csr_index_type which, input logic [15:0] value);
      csr_valid <= 1;
      csr_index <= which;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic csr_idle();
      csr_valid <= 0;
   endtask

   // one sample transfer, with random gaps before it
   task automatic put_sample(input logic signed [15:0] s, input logic [15:0] env,
         input logic [31:0] t, input logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= '{sample: s, envelope: env, sample_time: t, last: fin};
      do @(posedge clock); while (req_stall);
   endtask

   // record of a noisy sine-like wave: mostly clean alternation, some noise
   task automatic put_record(input int len, input int half_period, input bit noisy);
      logic signed [15:0] s;
      int amp;
      amp = int'($urandom_range(32767, 100));
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(9) == 0) s = 16'($urandom);
         else begin
            s = ((i / half_period) % 2) ? -16'(amp) : 16'(amp);
            s = s + 16'($urandom_range(40)) - 16'sd20;
         end
         now_time = now_time + $urandom_range(1000, 0);
         put_sample(s, 16'($urandom), ($urandom_range(40) == 0) ? $urandom : now_time,
            i == len - 1);
      end
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (FinishLatency) @(posedge clock);
   endtask

   initial begin
      int budget;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, equal neighbors, overflow, decreasing times, few crossings
      put_sample(16'sh7FFF, 16'hFFFF, 32'd0, 0);
      put_sample(-16'sh8000, 16'hFFFF, 32'd1, 0);
      put_sample(16'sh7FFF, 16'h0000, 32'd2, 0);
      put_sample(16'sh0000, 16'hFFFF, 32'd3, 0);
      put_sample(-16'sd1, 16'hFFFF, 32'hFFFF_FFFF, 1);  // big span jump
      put_sample(16'sd5, 16'd0, 32'd10, 1);              // single item record
      put_sample(16'sd3, 16'd0, 32'd100, 0);
      put_sample(-16'sd3, 16'd0, 32'd100, 0);            // crossing at same time
      put_sample(16'sd3, 16'd0, 32'd100, 0);
      put_sample(-16'sd3, 16'd0, 32'd100, 1);            // zero span
      put_sample(16'sd0, 16'd0, 32'd50, 0);
      put_sample(-16'sd1, 16'd0, 32'd40, 0);
      put_sample(16'sd9, 16'd0, 32'd30, 0);
      put_sample(-16'sd9, 16'd0, 32'd20, 1);             // decreasing times
      settle();

      write_reg(CSR_HYST, 16'hFFFF);
      write_reg(CSR_WINDOW_START, 16'd2);
      write_reg(CSR_WINDOW_END, 16'd1);                  // inverted window
      write_reg(CSR_UNUSED, 16'h1234);                   // ignored
      csr_idle();
      put_record(6, 1, 0);
      settle();
      write_reg(CSR_WINDOW_END, 16'hFFFF);
      write_reg(CSR_HYST, 16'd0);
      csr_idle();
      put_record(8, 1, 0);
      settle();

      // random phases over idle/stall rates and register settings
      budget = 600;
      for (int ph = 0; budget > 0; ph++) begin
         int len;
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 49; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 49; end
            default: begin send_idle = 17; recv_stall = 17; end
         endcase
         write_reg(CSR_WINDOW_START,
            16'($urandom_range(3) == 0 ? $urandom_range(4) : 0));
         write_reg(CSR_WINDOW_END,
            16'($urandom_range(3) == 0 ? $urandom_range(40) : 16'hFFFF));
         write_reg(CSR_HYST,
            16'($urandom_range(2) == 0 ? $urandom : $urandom_range(8192)));
         csr_idle();
         for (int r = 0; r < 4; r++) begin
            len = $urandom_range(30, 1);
            put_record(len, $urandom_range(4, 1), $urandom_range(3) == 0);
            budget -= len;
         end
         settle();
      end
      send_idle = 0;
      recv_stall = 0;
      settle();

      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/zcfe_pkg.sv
hdl/zcfe_alu.sv
hdl/zcfe_track.sv
hdl/zcfe_finish.sv
hdl/zero_crossing_frequency_estimator.sv
hdl/zcfe_checker.sv
tb/zcfe_checker.sv
tb/tb.sv
